>>> src/dlms_pkg.sv
// ----------------------------------------------------------------------------
// dlms_pkg
// Shared types, tag codes and phase encoding for the A-XDR list parser.
// ----------------------------------------------------------------------------
package dlms_pkg;

  localparam int unsigned ObisBytes = 6;
  localparam logic [31:0] HeaderMagicRst = 32'hE6E7000F;
  localparam logic [47:0] ClockObisRst   = 48'h0000010000FF;

  typedef enum logic [4:0] {
    PH_IDLE, PH_HEADER, PH_SKIP, PH_LIST_TAG, PH_LIST_LEN, PH_EL_TAG,
    PH_EL_COUNT, PH_OBIS_TAG, PH_OBIS_LEN, PH_OBIS, PH_VAL_TAG, PH_NUM,
    PH_STR_LEN, PH_STR_BYTES, PH_SC_TAG, PH_SC_COUNT, PH_SC_TYPE, PH_SC_VAL,
    PH_UNIT_TYPE, PH_UNIT_VAL
  } phase_e;

  typedef enum logic [1:0] {
    REC_ELEMENT = 2'd0, REC_PAYLOAD = 2'd1, REC_ERROR = 2'd2
  } rec_kind_e;

  typedef enum logic [2:0] {
    VK_U32 = 3'd0, VK_U16 = 3'd1, VK_S16 = 3'd2, VK_STR = 3'd3,
    VK_OCTET = 3'd4, VK_DATETIME = 3'd5
  } val_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE = 3'd0, ERR_HEADER = 3'd1, ERR_ROOT = 3'd2, ERR_STRUCT = 3'd3,
    ERR_TYPE = 3'd4
  } err_e;

  typedef enum logic [0:0] {
    CFG_MAGIC = 1'b0, CFG_CLOCK = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] TagList    = 8'h01;
  localparam logic [7:0] TagStruct  = 8'h02;
  localparam logic [7:0] TagU32     = 8'h06;
  localparam logic [7:0] TagOctet   = 8'h09;
  localparam logic [7:0] TagString  = 8'h0A;
  localparam logic [7:0] TagInt8    = 8'h0F;
  localparam logic [7:0] TagS16     = 8'h10;
  localparam logic [7:0] TagU16     = 8'h12;
  localparam logic [7:0] TagEnum    = 8'h16;
  localparam logic [7:0] ClockLen   = 8'h0C;

  // powers of ten from 10^0 to 10^10, held in 34 bits unsigned
  function automatic logic [33:0] pow10(input logic [3:0] e);
    logic [33:0] r;
    begin
      case (e)
        4'd0: r = 34'd1;
        4'd1: r = 34'd10;
        4'd2: r = 34'd100;
        4'd3: r = 34'd1000;
        4'd4: r = 34'd10000;
        4'd5: r = 34'd100000;
        4'd6: r = 34'd1000000;
        4'd7: r = 34'd10000000;
        4'd8: r = 34'd100000000;
        4'd9: r = 34'd1000000000;
        default: r = 34'd10000000000;
      endcase
      return r;
    end
  endfunction

endpackage

>>> src/dlms_cosem_list_parser.sv
// ----------------------------------------------------------------------------
// dlms_cosem_list_parser
// Byte-wise parser of a smart-meter A-XDR data-notification list.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on the in channel (data_byte_i, first_byte_i,
// final_byte_i with in_valid_i/in_ready_o), one byte per request. Each byte
// yields at most one record on the out channel (out_valid_o/out_ready_i):
// an element record, a string payload byte or a frame error.
// The parse step runs in the accept cycle and its raw record enters a first
// register; the scaler stage then loads the output register (out_valid_o).
// Throughput is one byte per cycle while in_ready_o is high, set by the
// combinational parse step; a positive scaler is applied in the record stage
// by one 32x34 multiply against a constant power-of-ten table.
// When the receiver stalls, both record registers fill and hold. A byte is
// still taken if it yields no record, if the first record register is empty,
// or if that register is freed in the same cycle; otherwise in_ready_o drops.
// Reset puts the parser in its idle phase with empty record registers and
// the configuration registers at their defaults. Configuration writes
// (cfg_we_i, cfg_idx_i, cfg_data_i) are taken at any edge.
// ----------------------------------------------------------------------------
module dlms_cosem_list_parser #(
  parameter int unsigned OBIS_BYTES = dlms_pkg::ObisBytes
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [47:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [7:0]              data_byte_i,
  input  logic                    first_byte_i,
  input  logic                    final_byte_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              record_kind_o,
  output logic [8*OBIS_BYTES-1:0] obis_code_o,
  output logic [2:0]              value_kind_o,
  output logic signed [32:0]      value_o,
  output logic signed [7:0]       decimal_exponent_o,
  output logic [7:0]              unit_code_o,
  output logic                    has_unit_o,
  output logic [7:0]              payload_byte_o,
  output logic signed [15:0]      clock_deviation_o,
  output logic [7:0]              clock_status_o,
  output logic [2:0]              error_code_o,
  output logic                    last_o
);
  import dlms_pkg::*;

  localparam int unsigned OW = 8 * OBIS_BYTES;

  // configuration
  logic [31:0] magic_q;
  logic [OW-1:0] clk_obis_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= HeaderMagicRst;
      clk_obis_q <= OW'(ClockObisRst);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAGIC: magic_q    <= cfg_data_i[31:0];
        CFG_CLOCK: clk_obis_q <= OW'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // parse state
  phase_e      ph_q, ph_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  rem_q, rem_d;
  logic [1:0]  ent_q, ent_d;
  logic [OW-1:0] obis_q, obis_d;
  logic [31:0] acc_q, acc_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  scl_q, scl_d;
  logic [7:0]  unit_q, unit_d;
  logic [15:0] dev_q, dev_d;
  logic [7:0]  stat_q, stat_d;

  // record stage 1 (raw), then output register
  typedef struct packed {
    logic [1:0]  rk;
    logic [OW-1:0] obis;
    logic [2:0]  vk;
    logic [31:0] acc;
    logic [7:0]  scl;
    logic        wu;
    logic [7:0]  unit;
    logic [7:0]  pay;
    logic [15:0] dev;
    logic [7:0]  stat;
    logic [2:0]  err;
    logic        last;
  } rec_t;

  rec_t rec_d;
  logic emit;
  logic acc_in;

  // parser step
  always_comb begin
    phase_e   ph;
    logic [7:0] b;
    logic [7:0] idx;
    logic     done, fin_el, is_last, errf;
    logic [2:0] ec;
    b = data_byte_i;
    ph = first_byte_i ? PH_HEADER : ph_q;
    pos_d = first_byte_i ? 4'd0 : pos_q;
    ph_d = ph; cnt_d = cnt_q; rem_d = rem_q; ent_d = ent_q; obis_d = obis_q;
    acc_d = acc_q; kind_d = kind_q; scl_d = scl_q; unit_d = unit_q;
    dev_d = dev_q; stat_d = stat_q;
    emit = 1'b0; errf = 1'b0; ec = ERR_NONE;
    done = 1'b0; fin_el = 1'b0; is_last = 1'b0;
    idx = acc_q[7:0] - cnt_q;
    rec_d = '0;
    rec_d.rk = REC_ELEMENT;
    case (ph)
      PH_HEADER: begin
        if (b != magic_q[8*(3-pos_d[1:0]) +: 8]) begin
          errf = 1'b1; ec = ERR_HEADER;
        end else begin
          pos_d = pos_d + 4'd1;
          if (pos_d >= 4'd4) ph_d = PH_SKIP;
        end
      end
      PH_SKIP: begin
        pos_d = pos_d + 4'd1;
        if (pos_d >= 4'd9) ph_d = PH_LIST_TAG;
      end
      PH_LIST_TAG: begin
        if (b != TagList) begin errf = 1'b1; ec = ERR_ROOT; end
        else ph_d = PH_LIST_LEN;
      end
      PH_LIST_LEN: begin
        rem_d = b;
        ph_d = (b != 8'd0) ? PH_EL_TAG : PH_IDLE;
      end
      PH_EL_TAG: begin
        if (b != TagStruct) begin errf = 1'b1; ec = ERR_STRUCT; end
        else ph_d = PH_EL_COUNT;
      end
      PH_EL_COUNT: begin
        if (b != 8'd2 && b != 8'd3) begin errf = 1'b1; ec = ERR_STRUCT; end
        else begin
          ent_d = b[1:0]; obis_d = '0; acc_d = '0; kind_d = VK_U32; scl_d = '0;
          unit_d = '0; dev_d = '0; stat_d = '0; ph_d = PH_OBIS_TAG;
        end
      end
      PH_OBIS_TAG: begin
        if (b != TagOctet) begin errf = 1'b1; ec = ERR_TYPE; end
        else ph_d = PH_OBIS_LEN;
      end
      PH_OBIS_LEN: begin
        if (b != 8'(OBIS_BYTES)) begin errf = 1'b1; ec = ERR_TYPE; end
        else begin cnt_d = '0; ph_d = PH_OBIS; end
      end
      PH_OBIS: begin
        obis_d = {obis_q[OW-9:0], b};
        cnt_d = cnt_q + 8'd1;
        if (cnt_d >= 8'(OBIS_BYTES)) ph_d = PH_VAL_TAG;
      end
      PH_VAL_TAG: begin
        acc_d = '0;
        case (b)
          TagU32:    begin kind_d = VK_U32; cnt_d = 8'd4; ph_d = PH_NUM; end
          TagU16:    begin kind_d = VK_U16; cnt_d = 8'd2; ph_d = PH_NUM; end
          TagS16:    begin kind_d = VK_S16; cnt_d = 8'd2; ph_d = PH_NUM; end
          TagString: begin kind_d = VK_STR; ph_d = PH_STR_LEN; end
          TagOctet:  begin kind_d = VK_OCTET; ph_d = PH_STR_LEN; end
          default:   begin errf = 1'b1; ec = ERR_TYPE; end
        endcase
      end
      PH_NUM: begin
        acc_d = {acc_q[23:0], b};
        cnt_d = cnt_q - 8'd1;
        done = (cnt_d == 8'd0);
      end
      PH_STR_LEN: begin
        acc_d = {24'd0, b};
        cnt_d = b;
        if (kind_q == VK_OCTET && b == ClockLen && obis_q == clk_obis_q)
          kind_d = VK_DATETIME;
        if ((kind_d == VK_STR || kind_d == VK_OCTET) && ent_q == 2'd2) begin
          emit = 1'b1;
          rec_d.rk = REC_ELEMENT; rec_d.obis = obis_q; rec_d.vk = kind_d;
          rec_d.acc = acc_d; rec_d.last = (rem_q <= 8'd1);
        end
        if (b == 8'd0) done = 1'b1;
        else ph_d = PH_STR_BYTES;
      end
      PH_STR_BYTES: begin
        if (kind_q == VK_DATETIME && idx >= 8'd9) begin
          if (idx == 8'd9) dev_d = {b, 8'd0};
          else if (idx == 8'd10) dev_d = {dev_q[15:8], b};
          else stat_d = b;
        end else begin
          emit = 1'b1;
          rec_d.rk = REC_PAYLOAD; rec_d.obis = obis_q; rec_d.vk = kind_q;
          rec_d.pay = b;
        end
        cnt_d = cnt_q - 8'd1;
        done = (cnt_d == 8'd0);
      end
      PH_SC_TAG: begin
        if (b != TagStruct) begin errf = 1'b1; ec = ERR_STRUCT; end
        else ph_d = PH_SC_COUNT;
      end
      PH_SC_COUNT: begin
        if (b != 8'd2) begin errf = 1'b1; ec = ERR_STRUCT; end
        else ph_d = PH_SC_TYPE;
      end
      PH_SC_TYPE: begin
        if (b != TagInt8) begin errf = 1'b1; ec = ERR_TYPE; end
        else ph_d = PH_SC_VAL;
      end
      PH_SC_VAL: begin
        scl_d = b; ph_d = PH_UNIT_TYPE;
      end
      PH_UNIT_TYPE: begin
        if (b != TagEnum) begin errf = 1'b1; ec = ERR_TYPE; end
        else ph_d = PH_UNIT_VAL;
      end
      PH_UNIT_VAL: begin
        unit_d = b; fin_el = 1'b1;
      end
      default: ph_d = PH_IDLE;
    endcase

    // value complete: scaler structure follows or element ends
    if (done) begin
      if (ent_q == 2'd3) ph_d = PH_SC_TAG;
      else fin_el = 1'b1;
    end
    if (fin_el) begin
      is_last = (rem_q <= 8'd1);
      if (!((kind_d == VK_STR || kind_d == VK_OCTET) && ent_q == 2'd2)) begin
        emit = 1'b1;
        rec_d = '0;
        rec_d.rk = REC_ELEMENT; rec_d.obis = obis_d; rec_d.vk = kind_d;
        rec_d.acc = acc_d; rec_d.scl = scl_d; rec_d.wu = (ph == PH_UNIT_VAL);
        rec_d.unit = unit_d; rec_d.dev = dev_d; rec_d.stat = stat_d;
        rec_d.last = is_last;
      end
      if (is_last) begin rem_d = '0; ph_d = PH_IDLE; end
      else begin rem_d = rem_q - 8'd1; ph_d = PH_EL_TAG; end
    end

    // truncated frame
    if (!errf && final_byte_i && ph_d != PH_IDLE) begin
      errf = 1'b1;
      if (ph_d == PH_HEADER) ec = ERR_HEADER;
      else if (ph_d == PH_SKIP || ph_d == PH_LIST_TAG || ph_d == PH_LIST_LEN)
        ec = ERR_ROOT;
      else ec = ERR_STRUCT;
    end
    if (errf) begin
      emit = 1'b1; rec_d = '0; rec_d.rk = REC_ERROR; rec_d.err = ec;
      ph_d = PH_IDLE;
    end
  end

  // handshake: stage 1 register feeds output register
  logic s1_v_q, out_v_q;
  rec_t s1_q;
  logic s1_adv;
  assign s1_adv = !out_v_q || out_ready_i;
  assign in_ready_o = !emit || !s1_v_q || s1_adv;
  assign acc_in = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_IDLE; pos_q <= '0; cnt_q <= '0; rem_q <= '0; ent_q <= '0;
      obis_q <= '0; acc_q <= '0; kind_q <= VK_U32; scl_q <= '0; unit_q <= '0;
      dev_q <= '0; stat_q <= '0;
    end else if (acc_in) begin
      ph_q <= ph_d; pos_q <= pos_d; cnt_q <= cnt_d; rem_q <= rem_d; ent_q <= ent_d;
      obis_q <= obis_d; acc_q <= acc_d; kind_q <= kind_d; scl_q <= scl_d;
      unit_q <= unit_d; dev_q <= dev_d; stat_q <= stat_d;
    end
  end

  // stage 1: raw record, multiply by power of ten
  logic s1_take;
  assign s1_take = acc_in && emit;
  logic signed [32:0] base_s1;
  logic               sat_s1;
  logic [3:0]         e_s1;
  logic signed [7:0]  scs;
  always_comb begin
    scs = (s1_q.wu && (s1_q.vk == VK_U32 || s1_q.vk == VK_U16 || s1_q.vk == VK_S16))
          ? $signed(s1_q.scl) : 8'sd0;
    sat_s1 = (scs > 8'sd10);
    e_s1 = (scs > 8'sd0) ? (sat_s1 ? 4'd10 : scs[3:0]) : 4'd0;
    if (s1_q.vk == VK_S16) base_s1 = 33'($signed(s1_q.acc[15:0]));
    else base_s1 = $signed({1'b0, s1_q.acc});
  end

  logic signed [67:0] prod;
  assign prod = base_s1 * $signed({1'b0, pow10(e_s1)});

  rec_t r_q;
  logic signed [32:0] val_d;
  always_comb begin
    logic nz;
    nz = (base_s1 != 33'sd0);
    val_d = base_s1;
    if (s1_q.vk == VK_U32 || s1_q.vk == VK_U16) begin
      if ((sat_s1 && nz) || prod > 68'sd4294967295) val_d = 33'sd4294967295;
      else val_d = prod[32:0];
    end else if (s1_q.vk == VK_S16) begin
      if ((sat_s1 && nz && !base_s1[32]) || prod > 68'sd2147483647)
        val_d = 33'sd2147483647;
      else if ((sat_s1 && base_s1[32]) || prod < -68'sd2147483648)
        val_d = -33'sd2147483648;
      else val_d = prod[32:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      if (s1_adv) out_v_q <= s1_v_q;
      if (s1_take) s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
    end
  end

  logic signed [32:0] val_q;
  logic signed [7:0]  exp_q;
  always_ff @(posedge clk_i) begin
    if (s1_take) s1_q <= rec_d;
    if (s1_adv && s1_v_q) begin
      r_q <= s1_q;
      val_q <= val_d;
      exp_q <= (scs < 8'sd0) ? scs : 8'sd0;
    end
  end

  assign out_valid_o        = out_v_q;
  assign record_kind_o      = r_q.rk;
  assign obis_code_o        = r_q.obis;
  assign value_kind_o       = r_q.vk;
  assign value_o            = (r_q.rk == REC_ELEMENT) ? val_q : 33'sd0;
  assign decimal_exponent_o = (r_q.rk == REC_ELEMENT) ? exp_q : 8'sd0;
  assign unit_code_o        = r_q.wu ? r_q.unit : 8'd0;
  assign has_unit_o         = r_q.wu;
  assign payload_byte_o     = r_q.pay;
  assign clock_deviation_o  = (r_q.vk == VK_DATETIME) ? $signed(r_q.dev) : 16'sd0;
  assign clock_status_o     = (r_q.vk == VK_DATETIME) ? r_q.stat : 8'd0;
  assign error_code_o       = r_q.err;
  assign last_o             = r_q.last;

endmodule

>>> src/dlms_checker.sv
// ----------------------------------------------------------------------------
// dlms_checker
// Port-level checks for the list parser, bound into the parser module.
// ----------------------------------------------------------------------------
module dlms_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] record_kind_o,
  input logic [2:0] error_code_o,
  input logic       has_unit_o,
  input logic [7:0] unit_code_o,
  input logic [7:0] payload_byte_o
);
  import dlms_pkg::*;

  // hold a stalled record
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(record_kind_o))
    else $error("record dropped under stall");

  // error records carry a code, others none
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((record_kind_o == REC_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code mismatch");

  // unit only with the unit flag
  a_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !has_unit_o |-> unit_code_o == 8'd0)
    else $error("unit without flag");

  // payload byte only on payload records
  a_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && record_kind_o != REC_PAYLOAD |-> payload_byte_o == 8'd0)
    else $error("stray payload byte");

endmodule

bind dlms_cosem_list_parser dlms_checker u_checker (.*);

>>> test/dlms_cosem_list_parser_test.sv
// ----------------------------------------------------------------------------
// dlms_cosem_list_parser_test
// Self-checking testbench: frames are sent byte by byte, every record is
// predicted by a local model of the list parser and compared field by field.
// ----------------------------------------------------------------------------
module dlms_cosem_list_parser_test;
  import dlms_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic [47:0]        obis;
    logic [2:0]         vkind;
    logic signed [32:0] value;
    logic signed [7:0]  dexp;
    logic [7:0]         unit;
    logic               has_unit;
    logic [7:0]         payload;
    logic signed [15:0] dev;
    logic [7:0]         status;
    logic [2:0]         err;
    logic               last;
  } record_t;

  localparam int StallLimit = 5000;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [47:0] cfg_data_i;
  logic in_valid_i, in_ready_o, first_byte_i, final_byte_i;
  logic [7:0] data_byte_i;
  logic out_valid_o, out_ready_i;
  logic [1:0] record_kind_o;
  logic [47:0] obis_code_o;
  logic [2:0] value_kind_o;
  logic signed [32:0] value_o;
  logic signed [7:0] decimal_exponent_o;
  logic [7:0] unit_code_o, payload_byte_o, clock_status_o;
  logic has_unit_o, last_o;
  logic signed [15:0] clock_deviation_o;
  logic [2:0] error_code_o;

  dlms_cosem_list_parser DUT (.*);

  // model state
  logic [31:0] magic_q;
  logic [47:0] clock_q;
  phase_e      phase_q;
  logic [3:0]  pos_q;
  logic [7:0]  cnt_q, remain_q;
  logic [1:0]  entries_q;
  logic [47:0] obis_q;
  logic [31:0] accum_q;
  logic [2:0]  kind_q;
  logic [7:0]  scaler_q, unit_q, status_q;
  logic [15:0] dev_q;

  record_t expected_records[$];
  int mismatches, records_seen, bytes_sent, idle_cycles;
  int send_gap_pct, recv_stall_pct;
  bit recv_hold, timed_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic record_t error_record(err_e code);
    record_t r;
    r = '0;
    r.kind = REC_ERROR;
    r.err = code;
    phase_q = PH_IDLE;
    return r;
  endfunction

  function automatic bit string_early();
    return (kind_q == VK_STR || kind_q == VK_OCTET) && entries_q == 2'd2;
  endfunction

  function automatic record_t element_record(bit with_unit, bit is_last);
    record_t r;
    longint u;
    int s;
    r = '0;
    s = with_unit ? int'($signed(scaler_q)) : 0;
    if (kind_q == VK_U32 || kind_q == VK_U16) begin
      u = longint'(accum_q);
      for (int i = 0; i < s; i++) begin
        u = u * 10;
        if (u > 64'hFFFFFFFF) begin
          u = 64'hFFFFFFFF;
          break;
        end
      end
      if (s < 0) r.dexp = scaler_q;
    end else if (kind_q == VK_S16) begin
      u = longint'($signed(accum_q[15:0]));
      for (int i = 0; i < s; i++) begin
        u = u * 10;
        if (u > 64'sd2147483647) begin
          u = 64'sd2147483647;
          break;
        end
        if (u < -64'sd2147483648) begin
          u = -64'sd2147483648;
          break;
        end
      end
      if (s < 0) r.dexp = scaler_q;
    end else begin
      u = longint'(accum_q);
    end
    r.kind = REC_ELEMENT;
    r.obis = obis_q;
    r.vkind = kind_q;
    r.value = u[32:0];
    r.unit = with_unit ? unit_q : 8'd0;
    r.has_unit = with_unit;
    if (kind_q == VK_DATETIME) begin
      r.dev = dev_q;
      r.status = status_q;
    end
    r.last = is_last;
    return r;
  endfunction

  function automatic int close_element(bit with_unit, output record_t r);
    bit is_last;
    int n;
    is_last = remain_q <= 1;
    n = 0;
    if (!string_early()) begin
      r = element_record(with_unit, is_last);
      n = 1;
    end
    if (is_last) begin
      remain_q = 0;
      phase_q = PH_IDLE;
    end else begin
      remain_q--;
      phase_q = PH_EL_TAG;
    end
    return n;
  endfunction

  function automatic int end_of_value(output record_t r);
    if (entries_q == 2'd3) begin
      phase_q = PH_SC_TAG;
      return 0;
    end
    return close_element(1'b0, r);
  endfunction

  // advance the parser model by one byte; returns the number of records
  function automatic int parse_byte(logic [7:0] b, bit first, bit fin, output record_t r);
    int n, m;
    record_t t;
    logic [7:0] idx;
    n = 0;
    r = '0;
    if (first) begin
      phase_q = PH_HEADER;
      pos_q = 0;
    end
    case (phase_q)
      PH_HEADER: begin
        if (b != magic_q[8*(3-pos_q[1:0]) +: 8]) begin
          r = error_record(ERR_HEADER);
          return 1;
        end
        pos_q++;
        if (pos_q >= 4) phase_q = PH_SKIP;
      end
      PH_SKIP: begin
        pos_q++;
        if (pos_q >= 9) phase_q = PH_LIST_TAG;
      end
      PH_LIST_TAG: begin
        if (b != TagList) begin
          r = error_record(ERR_ROOT);
          return 1;
        end
        phase_q = PH_LIST_LEN;
      end
      PH_LIST_LEN: begin
        remain_q = b;
        phase_q = (b != 0) ? PH_EL_TAG : PH_IDLE;
      end
      PH_EL_TAG: begin
        if (b != TagStruct) begin
          r = error_record(ERR_STRUCT);
          return 1;
        end
        phase_q = PH_EL_COUNT;
      end
      PH_EL_COUNT: begin
        if (b != 2 && b != 3) begin
          r = error_record(ERR_STRUCT);
          return 1;
        end
        entries_q = b[1:0];
        obis_q = 0; accum_q = 0; kind_q = 0; scaler_q = 0;
        unit_q = 0; dev_q = 0; status_q = 0;
        phase_q = PH_OBIS_TAG;
      end
      PH_OBIS_TAG: begin
        if (b != TagOctet) begin
          r = error_record(ERR_TYPE);
          return 1;
        end
        phase_q = PH_OBIS_LEN;
      end
      PH_OBIS_LEN: begin
        if (b != ObisBytes) begin
          r = error_record(ERR_TYPE);
          return 1;
        end
        cnt_q = 0;
        phase_q = PH_OBIS;
      end
      PH_OBIS: begin
        obis_q = {obis_q[39:0], b};
        cnt_q++;
        if (cnt_q >= ObisBytes) phase_q = PH_VAL_TAG;
      end
      PH_VAL_TAG: begin
        accum_q = 0;
        if (b == TagU32) begin
          kind_q = VK_U32; cnt_q = 4; phase_q = PH_NUM;
        end else if (b == TagU16) begin
          kind_q = VK_U16; cnt_q = 2; phase_q = PH_NUM;
        end else if (b == TagS16) begin
          kind_q = VK_S16; cnt_q = 2; phase_q = PH_NUM;
        end else if (b == TagString) begin
          kind_q = VK_STR; phase_q = PH_STR_LEN;
        end else if (b == TagOctet) begin
          kind_q = VK_OCTET; phase_q = PH_STR_LEN;
        end else begin
          r = error_record(ERR_TYPE);
          return 1;
        end
      end
      PH_NUM: begin
        accum_q = {accum_q[23:0], b};
        cnt_q--;
        if (cnt_q == 0) n = end_of_value(r);
      end
      PH_STR_LEN: begin
        accum_q = b;
        cnt_q = b;
        if (kind_q == VK_OCTET && b == ClockLen && obis_q == clock_q) kind_q = VK_DATETIME;
        if (string_early()) begin
          r = element_record(1'b0, remain_q <= 1);
          n = 1;
        end
        if (b == 0) begin
          m = end_of_value(t);
          if (m != 0) begin
            n = m;
            r = t;
          end
        end else begin
          phase_q = PH_STR_BYTES;
        end
      end
      PH_STR_BYTES: begin
        idx = accum_q[7:0] - cnt_q;
        if (kind_q == VK_DATETIME && idx >= 9) begin
          if (idx == 9) dev_q = {b, 8'd0};
          else if (idx == 10) dev_q = dev_q | b;
          else status_q = b;
        end else begin
          r = '0;
          r.kind = REC_PAYLOAD;
          r.obis = obis_q;
          r.vkind = kind_q;
          r.payload = b;
          n = 1;
        end
        cnt_q--;
        if (cnt_q == 0) begin
          m = end_of_value(t);
          if (m != 0) begin
            n = m;
            r = t;
          end
        end
      end
      PH_SC_TAG: begin
        if (b != TagStruct) begin
          r = error_record(ERR_STRUCT);
          return 1;
        end
        phase_q = PH_SC_COUNT;
      end
      PH_SC_COUNT: begin
        if (b != 2) begin
          r = error_record(ERR_STRUCT);
          return 1;
        end
        phase_q = PH_SC_TYPE;
      end
      PH_SC_TYPE: begin
        if (b != TagInt8) begin
          r = error_record(ERR_TYPE);
          return 1;
        end
        phase_q = PH_SC_VAL;
      end
      PH_SC_VAL: begin
        scaler_q = b;
        phase_q = PH_UNIT_TYPE;
      end
      PH_UNIT_TYPE: begin
        if (b != TagEnum) begin
          r = error_record(ERR_TYPE);
          return 1;
        end
        phase_q = PH_UNIT_VAL;
      end
      PH_UNIT_VAL: begin
        unit_q = b;
        n = close_element(1'b1, r);
      end
      default: phase_q = PH_IDLE;
    endcase
    if (fin && phase_q != PH_IDLE) begin
      if (phase_q == PH_HEADER) r = error_record(ERR_HEADER);
      else if (phase_q inside {PH_SKIP, PH_LIST_TAG, PH_LIST_LEN}) r = error_record(ERR_ROOT);
      else r = error_record(ERR_STRUCT);
      return 1;
    end
    return n;
  endfunction

  // drive one request and queue its predicted record
  task automatic send_byte(logic [7:0] b, bit first = 0, bit fin = 0);
    record_t r;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    first_byte_i <= first;
    final_byte_i <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (parse_byte(b, first, fin, r) != 0) expected_records = {expected_records, r};
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_records.size() != 0 && !timed_out) @(negedge clk_i);
    repeat (5) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [47:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_MAGIC) magic_q = data[31:0];
    else clock_q = data;
  endtask

  task automatic send_header();
    for (int i = 0; i < 4; i++) send_byte(magic_q[8*(3-i) +: 8], i == 0);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom_range(255)));
  endtask

  // one element with random content; corrupt at a random byte when asked
  task automatic send_element(bit is_final, bit corrupt);
    logic [7:0] bytes[$];
    int kind, len, ent;
    logic [47:0] obis;
    ent = $urandom_range(2, 3);
    kind = $urandom_range(0, 5);
    obis = ($urandom_range(3) == 0) ? clock_q : 48'({$urandom, $urandom});
    bytes = {TagStruct, 8'(ent), TagOctet, 8'(ObisBytes)};
    for (int i = 0; i < 6; i++) bytes = {bytes, obis[8*(5-i) +: 8]};
    case (kind)
      0: bytes = {bytes, TagU32};
      1: bytes = {bytes, TagU16};
      2: bytes = {bytes, TagS16};
      3: bytes = {bytes, TagString};
      default: bytes = {bytes, TagOctet};
    endcase
    if (kind <= 2) begin
      for (int i = 0; i < (kind == 0 ? 4 : 2); i++) begin
        case ($urandom_range(3))
          0: bytes = {bytes, 8'h00};
          1: bytes = {bytes, 8'hFF};
          default: bytes = {bytes, 8'($urandom_range(255))};
        endcase
      end
    end else begin
      len = (kind == 5) ? int'(ClockLen) : int'($urandom_range(0, 6));
      bytes = {bytes, 8'(len)};
      for (int i = 0; i < len; i++) bytes = {bytes, 8'($urandom_range(255))};
    end
    if (ent == 3) begin
      bytes = {bytes, TagStruct, 8'd2, TagInt8};
      case ($urandom_range(3))
        0: bytes = {bytes, 8'($urandom_range(0, 10))};
        1: bytes = {bytes, 8'($signed(-$urandom_range(1, 128)))};
        default: bytes = {bytes, 8'($urandom_range(255))};
      endcase
      bytes = {bytes, TagEnum, 8'($urandom_range(255))};
    end
    if (corrupt) bytes[$urandom_range(bytes.size() - 1)] = 8'($urandom_range(255));
    foreach (bytes[i]) send_byte(bytes[i], 0, is_final && i == bytes.size() - 1);
  endtask

  task automatic send_frame(int n_elem, bit corrupt);
    int bad;
    bad = corrupt ? $urandom_range(n_elem - 1) : -1;
    send_header();
    send_byte(TagList);
    send_byte(8'(n_elem));
    for (int i = 0; i < n_elem; i++) send_element(i == n_elem - 1, i == bad);
  endtask

  // record checker
  always @(posedge clk_i) begin
    record_t got, want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {record_kind_o, obis_code_o, value_kind_o, value_o, decimal_exponent_o,
             unit_code_o, has_unit_o, payload_byte_o, clock_deviation_o, clock_status_o,
             error_code_o, last_o};
      records_seen++;
      if (expected_records.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected record %p", got);
      end else begin
        want = expected_records.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("record mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready_i <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) timed_out <= 1'b1;
  end

  always @(posedge timed_out) begin
    $display("watchdog expired, %0d records outstanding", expected_records.size());
    $display("dlms_cosem_list_parser regression: fail");
    $finish;
  end

  task automatic test_directed();
    // header mismatch, bad root, empty list, truncation, idle bytes, a clean and a corrupt frame
    send_byte(8'h55);
    send_byte(magic_q[31:24], 1);
    send_byte(~magic_q[23:16]);
    send_byte(8'h01);
    send_byte(magic_q[31:24], 1);
    send_byte(magic_q[23:16], 0, 1);
    send_header();
    send_byte(8'h07);
    send_header();
    send_byte(TagList);
    send_byte(8'd0);
    send_byte(8'hAA);
    send_header();
    send_byte(TagList, 0, 1);
    send_frame(2, 0);
    send_frame(1, 1);
  endtask

  task automatic test_random(int quota);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < quota) begin
      case ($urandom_range(9))
        0: send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
        1: send_frame($urandom_range(1, 3), 1);
        default: send_frame($urandom_range(1, 4), 0);
      endcase
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1;
        repeat (200) @(negedge clk_i);
        recv_hold = 0;
      end
      send_frame(3, 0);
    join
    drain();
  endtask

  initial begin
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = 0; cfg_data_i = '0;
    in_valid_i = 0; data_byte_i = 0; first_byte_i = 0; final_byte_i = 0;
    out_ready_i = 0; recv_hold = 0; timed_out = 0;
    mismatches = 0; records_seen = 0; bytes_sent = 0; idle_cycles = 0;
    magic_q = HeaderMagicRst; clock_q = ClockObisRst;
    phase_q = PH_IDLE; pos_q = 0; cnt_q = 0; remain_q = 0; entries_q = 0;
    obis_q = 0; accum_q = 0; kind_q = 0; scaler_q = 0; unit_q = 0; dev_q = 0;
    status_q = 0;
    send_gap_pct = 8; recv_stall_pct = 58;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    test_directed();
    test_random(600);
    write_cfg(CFG_MAGIC, 48'hFFFFFFFF);
    write_cfg(CFG_CLOCK, 48'hFFFFFFFFFFFF);
    send_gap_pct = 58; recv_stall_pct = 8;
    test_random(600);
    test_backpressure();
    write_cfg(CFG_MAGIC, 48'h0);
    write_cfg(CFG_CLOCK, 48'h0);
    send_gap_pct = 0; recv_stall_pct = 0;
    test_random(300);
    write_cfg(CFG_MAGIC, {16'd0, HeaderMagicRst});
    write_cfg(CFG_CLOCK, ClockObisRst);
    test_random(300);
    drain();
    repeat (20) @(negedge clk_i);

    $display("sent %0d frame bytes, checked %0d records over four register settings",
             bytes_sent, records_seen);
    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("dlms_cosem_list_parser regression: pass");
    end else begin
      $display("%0d mismatches, %0d records missing", mismatches, expected_records.size());
      $display("dlms_cosem_list_parser regression: fail");
    end
    $finish;
  end

endmodule
